/* sv/nar_pkg.sv */
// ----------------------------------------------------------------------------
// nar_pkg
// shared types and constants of the neighbor anti-replay window
// ----------------------------------------------------------------------------
package nar_pkg;

   localparam int WINDOW_BITS_DEF    = 64;
   localparam int NEIGHBOR_SLOTS_DEF = 16;

   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 16;
   localparam int KEY_W    = 12;
   localparam int SEQ_W    = 12;
   localparam int VALUE_W  = KEY_W + SEQ_W;
   localparam int STATUS_W = 3;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   localparam logic [SEQ_W-1:0]   SEQ_MAX     = 12'h0fff;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'd32768;

   typedef enum logic [1:0] {
      OP_RECV  = 2'd0,
      OP_NEXT  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NEW_COUNT = 3'd1,
      STAT_DUP_AUTH  = 3'd2,
      STAT_STALE     = 3'd3,
      STAT_AUTH_FAIL = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // per-slot entry without the replay bitmap
   typedef struct packed {
      logic [VALUE_W-1:0] left_edge;
      logic               count_valid;
      logic [COUNT_W-1:0] stored_count;
      logic [KEY_W-1:0]   out_key;
      logic [SEQ_W-1:0]   out_seq;
   } entry_type;

endpackage

/* sv/nar_ram.sv */
// ----------------------------------------------------------------------------
// nar_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module nar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/neighbor_anti_replay_window.sv */
// ----------------------------------------------------------------------------
// neighbor_anti_replay_window
// per-neighbor replay window and outbound key/sequence table in one ram
// ----------------------------------------------------------------------------
// result: the result register loads at the end of the exec cycle, which
//    waits while the result register is still full
// requests: one at a time; a new one is taken only back in idle, after the
//    ram read then write-back of the slot entry
// reset: synchronous; per-slot valid flops clear at once, an entry that is
//    not valid reads as all zero, so no clearing pass is needed
// ----------------------------------------------------------------------------
module neighbor_anti_replay_window
   import nar_pkg::*;
#(
   parameter int WINDOW_BITS    = WINDOW_BITS_DEF,
   parameter int NEIGHBOR_SLOTS = NEIGHBOR_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // neighbor_slot, security_count, key_id, sequence_req, auth_ok, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, out_key_id, out_sequence, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // slot index and bitmap index widths
   localparam int SW    = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
   localparam int IW    = $clog2(WINDOW_BITS);
   localparam int ENT_W = $bits(entry_type);
   localparam int EW    = WINDOW_BITS + ENT_W;
   localparam int NUM_SLOT_CODES = 2 ** SLOT_W;

   localparam logic [VALUE_W-1:0]     WIN_SIZE = VALUE_W'(WINDOW_BITS);
   localparam logic [VALUE_W-1:0]     WIN_LAST = VALUE_W'(WINDOW_BITS - 1);
   localparam logic [IW-1:0]          LAST_POS = IW'(WINDOW_BITS - 1);
   localparam logic [WINDOW_BITS-1:0] BIT_ONE  = {{(WINDOW_BITS-1){1'b0}}, 1'b1};

   // slot code folded onto the table depth, worked out at elaboration
   function automatic logic [NUM_SLOT_CODES-1:0][SW-1:0] build_slot_map();
      logic [NUM_SLOT_CODES-1:0][SW-1:0] m;
      for (int i = 0; i < NUM_SLOT_CODES; i++) begin
         m[i] = SW'(i % NEIGHBOR_SLOTS);
      end
      return m;
   endfunction

   localparam logic [NUM_SLOT_CODES-1:0][SW-1:0] SLOT_MAP = build_slot_map();

   // request fields
   logic [SLOT_W-1:0]  req_slot;
   logic [COUNT_W-1:0] req_count;
   logic [KEY_W-1:0]   req_key;
   logic [SEQ_W-1:0]   req_seq;
   logic               req_auth;
   logic               req_accept;

   assign req_slot   = req_tdata[SLOT_W-1:0];
   assign req_count  = req_tdata[SLOT_W +: COUNT_W];
   assign req_key    = req_tdata[SLOT_W+COUNT_W +: KEY_W];
   assign req_seq    = req_tdata[SLOT_W+COUNT_W+KEY_W +: SEQ_W];
   assign req_auth   = req_tdata[SLOT_W+COUNT_W+KEY_W+SEQ_W];
   assign req_accept = req_tvalid && req_tready;

   // request holding registers
   state_type          state_ff, state_in;
   opcode_type         op_ff;
   logic [SW-1:0]      slot_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               auth_ff;

   // per-slot valid flops stand in for a cleared ram
   logic [NEIGHBOR_SLOTS-1:0] valid_ff, valid_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ram interface
   logic [SW-1:0] rd_addr;
   logic [EW-1:0] rd_word;
   logic [EW-1:0] wr_word;
   logic          ram_we;
   logic          exec_go;

   // entry update
   entry_type             ent, nxt_ent;
   logic [WINDOW_BITS-1:0] bm, bm1, nxt_bm;
   logic                   changed;
   logic [COUNT_W-1:0]     fwd;
   logic [VALUE_W-1:0]     le1, rel_pos, slide;
   logic [IW-1:0]          dist_idx, set_pos;
   logic                   in_win, hit;
   status_type             status;
   logic [KEY_W-1:0]       res_key;
   logic [SEQ_W-1:0]       res_seq;

   // read at accept so the entry is there in the exec cycle; hold the address
   // while waiting on the result register so the read data stays put
   assign rd_addr = req_accept ? SLOT_MAP[req_slot] : slot_ff;

   nar_ram #(
      .WIDTH (EW),
      .DEPTH (NEIGHBOR_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_ff),
      .wr_data (wr_word),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // sequencer: idle takes a request, exec does the read-modify-write
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      exec_go    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            exec_go = !rsp_valid_ff || rsp_tready;
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // entry update for the request in exec
   always_comb begin
      ent = valid_ff[slot_ff] ? entry_type'(rd_word[ENT_W-1:0]) : '0;
      bm  = valid_ff[slot_ff] ? rd_word[EW-1:ENT_W] : '0;

      changed  = ent.count_valid && (ent.stored_count != count_ff);
      fwd      = count_ff - ent.stored_count;
      // a new security count starts the inbound window over
      le1      = changed ? '0 : ent.left_edge;
      bm1      = changed ? '0 : bm;
      rel_pos  = value_ff - le1;
      dist_idx = rel_pos[IW-1:0];
      in_win   = rel_pos < WIN_SIZE;
      hit      = in_win && bm1[dist_idx];
      // distance the left edge moves when the value lands past the window
      slide    = rel_pos - WIN_LAST;

      nxt_ent = ent;
      nxt_bm  = bm;
      set_pos = dist_idx;
      status  = STAT_OK;
      res_key = '0;
      res_seq = '0;

      unique case (op_ff)
         OP_RECV: begin
            if (changed && (fwd > COUNT_LIMIT)) begin
               status = STAT_STALE;
            end else if (!changed && (value_ff < ent.left_edge)) begin
               status = STAT_STALE;
            end else if (!auth_ff) begin
               status = STAT_AUTH_FAIL;
            end else begin
               nxt_ent.left_edge = le1;
               nxt_bm            = bm1;
               if (changed) begin
                  nxt_ent.count_valid  = 1'b0;
                  nxt_ent.stored_count = '0;
               end
               if (hit) begin
                  status = STAT_DUP_AUTH;
               end else begin
                  // bitmap bit i stands for value left_edge + i, so sliding
                  // the window is a right shift that drops old positions
                  if (!in_win) begin
                     nxt_ent.left_edge = value_ff - WIN_LAST;
                     nxt_bm  = (slide >= WIN_SIZE) ? '0 : (bm1 >> slide[IW-1:0]);
                     set_pos = LAST_POS;
                  end
                  nxt_bm               = nxt_bm | (BIT_ONE << set_pos);
                  nxt_ent.count_valid  = 1'b1;
                  nxt_ent.stored_count = count_ff;
                  status = changed ? STAT_NEW_COUNT : STAT_OK;
               end
            end
         end
         OP_NEXT: begin
            // sequence wrap carries into the key id
            if (ent.out_seq == SEQ_MAX) begin
               nxt_ent.out_seq = '0;
               nxt_ent.out_key = ent.out_key + KEY_W'(1);
            end else begin
               nxt_ent.out_seq = ent.out_seq + SEQ_W'(1);
            end
            res_key = nxt_ent.out_key;
            res_seq = nxt_ent.out_seq;
         end
         OP_CLEAR: begin
         end
         OP_NONE: begin
         end
      endcase
   end

   assign wr_word = {nxt_bm, nxt_ent};
   assign ram_we  = exec_go && ((op_ff == OP_RECV) || (op_ff == OP_NEXT));

   // valid flops: written entries become valid, a slot reset drops the entry
   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[slot_ff] = 1'b1;
      end else if (exec_go && (op_ff == OP_CLEAR)) begin
         valid_in[slot_ff] = 1'b0;
      end
   end

   // result register: loads in exec, frees on the downstream accept
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(RSP_DATA_W-STATUS_W-KEY_W-SEQ_W){1'b0}},
                         res_seq, res_key, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= opcode_type'(req_tuser);
         slot_ff  <= SLOT_MAP[req_slot];
         count_ff <= req_count;
         value_ff <= {req_key, req_seq};
         auth_ff  <= req_auth;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted request always moves the sequencer into exec
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter exec");

   // the table is written only when the result register can take the result
   a_write_with_result: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready)))
      else $error("table written without a result slot");

   // a slot reset leaves the entry reading as zero
   a_clear_drops_valid: assert property (@(posedge clock) disable iff (reset)
      (exec_go && (op_ff == OP_CLEAR)) |=> !valid_ff[slot_ff])
      else $error("slot reset left entry valid");

   // a new result appears only out of exec
   a_result_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EXEC))
      else $error("result raised outside exec");

endmodule

/* verif/neighbor_anti_replay_window_tb.sv */
// ----------------------------------------------------------------------------
// neighbor_anti_replay_window_tb
// drives receive, next-sequence, clear and unused requests into the replay
// table and checks every response field against typed-in values for the
// directed rows that carry them, else against a cycle-free model of the
// per-neighbor windows and outbound counters kept inside the bench
module neighbor_anti_replay_window_tb;
   import nar_pkg::*;

   localparam int WIN              = WINDOW_BITS_DEF;
   localparam int SLOTS            = NEIGHBOR_SLOTS_DEF;
   localparam int RANDOM_PER_PHASE = 310;
   localparam int SEQ_RUN_ITEMS    = 60;
   localparam int HOLD_CYCLES      = 300;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DIRECTED_ROWS    = 24;

   // one request as the host sees it
   typedef struct {
      opcode_type         op;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      logic [KEY_W-1:0]   key;
      logic [SEQ_W-1:0]   seq;
      logic               auth;
   } req_type;

   // one response
   typedef struct {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [SEQ_W-1:0] seq;
   } verdict_type;

   // directed row: request, then whether the response is typed in, then the response
   typedef struct {
      opcode_type         op;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
      logic [KEY_W-1:0]   key;
      logic [SEQ_W-1:0]   seq;
      logic               auth;
      logic               typed;
      status_type         status;
      logic [KEY_W-1:0]   out_key;
      logic [SEQ_W-1:0]   out_seq;
   } directed_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // neighbor_slot, security_count, key_id, sequence_req, auth_ok, zero fill
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // opcode
   logic [1:0]            req_tuser  = OP_RECV;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // status, out_key_id, out_sequence, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   neighbor_anti_replay_window dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------
   // bench copy of the neighbor table
   // ---------------------------------------------------------------------------
   logic [VALUE_W-1:0] rx_lo    [SLOTS];
   logic [WIN-1:0]     rx_seen  [SLOTS];
   logic               rx_valid [SLOTS];
   logic [COUNT_W-1:0] rx_count [SLOTS];
   logic [KEY_W-1:0]   tx_key   [SLOTS];
   logic [SEQ_W-1:0]   tx_seq   [SLOTS];

   verdict_type pending_verdicts [$];

   int unsigned send_gap_pct   = 7;
   int unsigned recv_stall_pct = 82;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   logic        hold_on        = 1'b0;
   event        hold_off_go;

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         rx_lo[s]    = '0;
         rx_seen[s]  = '0;
         rx_valid[s] = 1'b0;
         rx_count[s] = '0;
         tx_key[s]   = '0;
         tx_seq[s]   = '0;
      end
   end

   // drop the inbound side of one slot, outbound counters stay
   function automatic void clear_inbound_state(int s);
      rx_lo[s]    = '0;
      rx_seen[s]  = '0;
      rx_valid[s] = 1'b0;
      rx_count[s] = '0;
   endfunction

   // response of the table to one request, updating the bench copy
   function automatic verdict_type table_response(req_type r);
      verdict_type        v;
      logic [VALUE_W-1:0] value;
      logic [VALUE_W-1:0] new_lo;
      logic [COUNT_W-1:0] fwd_count;
      logic               changed;
      int                 s;
      v.status = STAT_OK;
      v.key    = '0;
      v.seq    = '0;
      s        = int'(r.slot) % SLOTS;
      value    = {r.key, r.seq};
      case (r.op)
         OP_RECV: begin
            changed   = rx_valid[s] && (rx_count[s] != r.count);
            fwd_count = r.count - rx_count[s];
            // count far behind, or same count below the window: stale even before auth
            if (changed && fwd_count > COUNT_LIMIT) begin
               v.status = STAT_STALE;
            end else if (!changed && value < rx_lo[s]) begin
               v.status = STAT_STALE;
            end else if (!r.auth) begin
               v.status = STAT_AUTH_FAIL;
            end else begin
               if (changed) clear_inbound_state(s);
               if (value < rx_lo[s] ||
                   (value - rx_lo[s] < WIN && rx_seen[s][value % WIN])) begin
                  v.status = STAT_DUP_AUTH;
               end else begin
                  if (value - rx_lo[s] >= WIN) begin
                     new_lo = VALUE_W'(value - WIN + 1);
                     if (new_lo - rx_lo[s] >= WIN) begin
                        rx_seen[s] = '0;
                     end else begin
                        for (logic [VALUE_W-1:0] p = rx_lo[s]; p != new_lo; p++)
                           rx_seen[s][p % WIN] = 1'b0;
                     end
                     rx_lo[s] = new_lo;
                  end
                  rx_seen[s][value % WIN] = 1'b1;
                  rx_valid[s] = 1'b1;
                  rx_count[s] = r.count;
                  v.status = changed ? STAT_NEW_COUNT : STAT_OK;
               end
            end
         end
         OP_NEXT: begin
            // sequence rolls over into the key id
            if (tx_seq[s] == SEQ_MAX) begin
               tx_seq[s] = '0;
               tx_key[s] = tx_key[s] + KEY_W'(1);
            end else begin
               tx_seq[s] = tx_seq[s] + SEQ_W'(1);
            end
            v.key = tx_key[s];
            v.seq = tx_seq[s];
         end
         OP_CLEAR: begin
            clear_inbound_state(s);
            tx_key[s] = '0;
            tx_seq[s] = '0;
         end
         default: ;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------------------
   // request side: offer one request, wait for the handshake, log its verdict
   // ---------------------------------------------------------------------------
   task automatic send_request(input req_type r, input logic use_typed,
                               input verdict_type typed);
      verdict_type v;
      // random gap before the request goes out
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.auth, r.seq, r.key, r.count, r.slot};
      req_tuser  <= r.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // accepted at this edge
      v = table_response(r);
      pending_verdicts.push_back(use_typed ? typed : v);
   endtask

   // park the request side until every outstanding response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // response side: random stalls plus one long hold-off on demand
   // ---------------------------------------------------------------------------
   initial begin
      forever begin
         @(hold_off_go);
         @(posedge clock);
         hold_on <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_on <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each accepted response with the oldest pending verdict
   verdict_type want;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status,
                      rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tdata[14:3] !== want.key) begin
               $error("out_key_id mismatch: expected %h, actual %h", want.key,
                      rsp_tdata[14:3]);
               error_count++;
            end
            if (rsp_tdata[26:15] !== want.seq) begin
               $error("out_sequence mismatch: expected %h, actual %h", want.seq,
                      rsp_tdata[26:15]);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** neighbor_anti_replay_window: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // directed requests
   // ---------------------------------------------------------------------------
   directed_row_type directed_tab [DIRECTED_ROWS] = '{
      // fresh slot accepts, same value again is a duplicate, then auth fails
      '{OP_RECV, 4'd0, 16'h0000, 12'h000, 12'h000, 1'b1, 1'b1, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd0, 16'h0000, 12'h000, 12'h000, 1'b1, 1'b1, STAT_DUP_AUTH, 12'h000, 12'h000},
      '{OP_RECV, 4'd0, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b1, STAT_AUTH_FAIL, 12'h000, 12'h000},
      '{OP_NEXT, 4'd0, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b1, STAT_OK, 12'h000, 12'h001},
      '{OP_NEXT, 4'd0, 16'hffff, 12'hfff, 12'hfff, 1'b1, 1'b1, STAT_OK, 12'h000, 12'h002},
      // top value on the last slot, then below the left edge
      '{OP_RECV, 4'd15, 16'hffff, 12'hfff, 12'hfff, 1'b1, 1'b1, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'hffff, 12'h000, 12'h000, 1'b1, 1'b1, STAT_STALE, 12'h000, 12'h000},
      // count wraps forward by one: window restarts
      '{OP_RECV, 4'd15, 16'h0000, 12'h000, 12'h005, 1'b1, 1'b1, STAT_NEW_COUNT, 12'h000, 12'h000},
      // forward distance just past half range is stale, exactly half is taken
      '{OP_RECV, 4'd15, 16'h8001, 12'h000, 12'h000, 1'b1, 1'b1, STAT_STALE, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'h8000, 12'h000, 12'h000, 1'b0, 1'b1, STAT_AUTH_FAIL, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'h8000, 12'h000, 12'h000, 1'b1, 1'b1, STAT_NEW_COUNT, 12'h000, 12'h000},
      // slide by one, stale check ahead of auth, duplicate inside the window
      '{OP_RECV, 4'd15, 16'h8000, 12'h000, 12'h040, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'h8000, 12'h000, 12'h000, 1'b0, 1'b0, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'h8000, 12'h000, 12'h040, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'h8000, 12'h000, 12'h001, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000},
      // long jump clears the whole bitmap
      '{OP_RECV, 4'd5, 16'h1234, 12'h800, 12'h000, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd5, 16'h1234, 12'h800, 12'h000, 1'b0, 1'b0, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd5, 16'h1234, 12'hfff, 12'hfff, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000},
      // clearing a slot resets both directions
      '{OP_CLEAR, 4'd0, 16'hffff, 12'hfff, 12'hfff, 1'b1, 1'b1, STAT_OK, 12'h000, 12'h000},
      '{OP_NEXT, 4'd0, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b1, STAT_OK, 12'h000, 12'h001},
      '{OP_RECV, 4'd0, 16'hffff, 12'h000, 12'h000, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000},
      // unused opcode does nothing and reports zeros
      '{OP_NONE, 4'd15, 16'hffff, 12'hfff, 12'hfff, 1'b1, 1'b1, STAT_OK, 12'h000, 12'h000},
      '{OP_CLEAR, 4'd15, 16'h0000, 12'h000, 12'h000, 1'b0, 1'b1, STAT_OK, 12'h000, 12'h000},
      '{OP_RECV, 4'd15, 16'hffff, 12'h000, 12'h000, 1'b1, 1'b0, STAT_OK, 12'h000, 12'h000}
   };

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      req_type     r;
      verdict_type typed;
      int unsigned pick;
      logic [31:0] near;
      int          s;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_tab[i]) begin
         r.op       = directed_tab[i].op;
         r.slot     = directed_tab[i].slot;
         r.count    = directed_tab[i].count;
         r.key      = directed_tab[i].key;
         r.seq      = directed_tab[i].seq;
         r.auth     = directed_tab[i].auth;
         typed.status = directed_tab[i].status;
         typed.key    = directed_tab[i].out_key;
         typed.seq    = directed_tab[i].out_seq;
         send_request(r, directed_tab[i].typed, typed);
      end

      // step one slot's outbound sequence through a run of next-sequence requests
      for (int n = 0; n < SEQ_RUN_ITEMS; n++) begin
         r.op    = OP_NEXT;
         r.slot  = 4'd9;
         r.count = COUNT_W'($urandom);
         r.key   = KEY_W'($urandom);
         r.seq   = SEQ_W'($urandom);
         r.auth  = 1'($urandom);
         send_request(r, 1'b0, typed);
      end
      drain_responses();

      // random phases: sender idles little / receiver a lot, then swapped, then none
      for (int ph = 0; ph < 3; ph++) begin
         send_gap_pct   = (ph == 0) ? 7  : (ph == 1) ? 82 : 0;
         recv_stall_pct = (ph == 0) ? 82 : (ph == 1) ? 7  : 0;
         // long receiver hold-off while requests keep coming, so the block backs up
         if (ph == 2) -> hold_off_go;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            r.slot  = SLOT_W'($urandom_range(SLOTS - 1));
            r.count = COUNT_W'($urandom);
            r.key   = KEY_W'($urandom);
            r.seq   = SEQ_W'($urandom);
            r.auth  = ($urandom_range(9) != 0);
            s       = int'(r.slot);
            pick    = $urandom_range(99);
            if (pick < 75)      r.op = OP_RECV;
            else if (pick < 93) r.op = OP_NEXT;
            else if (pick < 97) r.op = OP_CLEAR;
            else                r.op = OP_NONE;
            if (r.op == OP_RECV) begin
               // mostly values around the current window so duplicates and slides happen
               if ($urandom_range(99) < 80) begin
                  near = {8'h00, rx_lo[s]} + $urandom_range(WIN + 24) - 32'd8;
                  {r.key, r.seq} = near[VALUE_W-1:0];
               end
               // mostly the stored count, some small steps, some near half range
               pick = $urandom_range(99);
               if (rx_valid[s] && pick < 75)
                  r.count = rx_count[s];
               else if (pick < 90)
                  r.count = COUNT_W'(rx_count[s] + $urandom_range(1, 4));
               else if (pick < 95)
                  r.count = COUNT_W'(rx_count[s] + 16'h8000 + $urandom_range(1));
            end
            send_request(r, 1'b0, typed);
         end
         // sender waits for every outstanding response
         drain_responses();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_verdicts.size() == 0)
         $display("** neighbor_anti_replay_window: PASSED **");
      else
         $display("** neighbor_anti_replay_window: FAILED **");
      $finish;
   end

endmodule

/* neighbor_anti_replay_window.f */
sv/nar_pkg.sv
sv/nar_ram.sv
sv/neighbor_anti_replay_window.sv
verif/neighbor_anti_replay_window_tb.sv
